// ===== hw/rtl/rfa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the rational fraction unit.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int MODE_W = 2;
  localparam int NUM_W  = 24;
  localparam int DEN_W  = 16;
  localparam int RNUM_W = 48;
  localparam int RDEN_W = 40;
  localparam int DIV_W  = 40;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int QDEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIV = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SMP = 2'd3;

  // work class picked by the front end
  typedef enum logic [2:0] {
    CL_PASS,
    CL_ADDEQ,
    CL_ADD,
    CL_MUL,
    CL_DIVIDE,
    CL_SIMP
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic             b_gt_a;
    logic [NUM_W-1:0] an;
    logic [DEN_W-1:0] ad;
    logic [NUM_W-1:0] bn;
    logic [DEN_W-1:0] bd;
  } q_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rational_fraction_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Fraction add, multiply, divide and gcd simplify with a queued back end.
// ----------------------------------------------------------------------------
//  channel | ports                                     | direction
//  in      | in_valid in_stall in_mode in_a_* in_b_*   | item in
//  out     | out_valid out_stall out_res_* out_skipped | result out
//
// pass-through, equal-denominator add: straight to the result register; multiply: S_M1, S_M2, then the result
// other add: one division of the larger denominator by the smaller, then multiplies and an add
// divide: cross multiplies, then as simplify; simplify: one division per euclid step plus two quotients
// each division runs on the single restoring divider, one bit per cycle
// synchronous active-low reset empties the queue and drops any pending result
// a stalled result holds; the queue keeps taking items until two are waiting
module rational_fraction_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rfa_pkg::MODE_W-1:0] in_mode,
  input  wire logic [rfa_pkg::NUM_W-1:0]  in_a_num,
  input  wire logic [rfa_pkg::DEN_W-1:0]  in_a_den,
  input  wire logic [rfa_pkg::NUM_W-1:0]  in_b_num,
  input  wire logic [rfa_pkg::DEN_W-1:0]  in_b_den,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rfa_pkg::RNUM_W-1:0]      out_res_num,
  output logic [rfa_pkg::RDEN_W-1:0]      out_res_den,
  output logic                            out_skipped
);
  import rfa_pkg::*;

  logic      q_full;
  logic      push;
  q_item_t   push_item;
  logic      head_valid;
  q_item_t   head_item;
  logic      pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  rfa_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_a_num  (in_a_num),
    .in_a_den  (in_a_den),
    .in_b_num  (in_b_num),
    .in_b_den  (in_b_den),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  rfa_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rfa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_num (out_res_num),
    .out_res_den (out_res_den),
    .out_skipped (out_skipped)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_front
// Classifies an incoming item and hands it to the queue.
// ----------------------------------------------------------------------------
module rfa_front (
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [rfa_pkg::MODE_W-1:0] in_mode,
  input  wire logic [rfa_pkg::NUM_W-1:0]  in_a_num,
  input  wire logic [rfa_pkg::DEN_W-1:0]  in_a_den,
  input  wire logic [rfa_pkg::NUM_W-1:0]  in_b_num,
  input  wire logic [rfa_pkg::DEN_W-1:0]  in_b_den,
  input  wire logic                       q_full,
  output logic                            push,
  output rfa_pkg::q_item_t                push_item
);
  import rfa_pkg::*;

  logic a_zero;
  logic b_zero;

  assign a_zero = (in_a_num == '0) || (in_a_den == '0);
  assign b_zero = (in_b_num == '0) || (in_b_den == '0);

  always_comb begin
    push_item.an     = in_a_num;
    push_item.ad     = in_a_den;
    push_item.bn     = in_b_num;
    push_item.bd     = in_b_den;
    push_item.b_gt_a = in_b_den > in_a_den;
    unique case (in_mode)
      MODE_ADD: begin
        if (a_zero || b_zero) push_item.cls = CL_PASS;
        else if (in_a_den == in_b_den) push_item.cls = CL_ADDEQ;
        else push_item.cls = CL_ADD;
      end
      MODE_MUL: push_item.cls = CL_MUL;
      MODE_DIV: push_item.cls = CL_DIVIDE;
      MODE_SMP: push_item.cls = a_zero ? CL_PASS : CL_SIMP;
      default:  push_item.cls = CL_PASS;
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_queue
// Two-entry queue between the front end and the execution back end.
// ----------------------------------------------------------------------------
module rfa_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire rfa_pkg::q_item_t push_item,
  output logic             full,
  output logic             head_valid,
  output rfa_pkg::q_item_t head_item,
  input  wire logic        pop
);
  import rfa_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  q_item_t               items_r [QDEPTH];
  logic [PW-1:0]         wp_r, wp_nxt;
  logic [PW-1:0]         rp_r, rp_nxt;
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == ($clog2(QDEPTH+1))'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_item  = items_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) items_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rfa_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rfa_pkg::div_req_t req,
  output rfa_pkg::div_rsp_t rsp
);
  import rfa_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      quo_nxt  = req.dvd;
      rem_nxt  = '0;
      dvs_nxt  = req.dvs;
    end else if (busy_r) begin
      // trial subtract decides the next quotient bit
      if (!diff[DIV_W+1]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_back
// Execution sequencer: shared multiplier, gcd loop on the divider, result reg.
// ----------------------------------------------------------------------------
module rfa_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       head_valid,
  input  wire rfa_pkg::q_item_t           head_item,
  output logic                            pop,
  output rfa_pkg::div_req_t               div_req,
  input  wire rfa_pkg::div_rsp_t          div_rsp,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [rfa_pkg::RNUM_W-1:0]      out_res_num,
  output logic [rfa_pkg::RDEN_W-1:0]      out_res_den,
  output logic                            out_skipped
);
  import rfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ADIV, S_ASC, S_ASC2, S_X1, S_X2, S_X3, S_M1, S_M2,
    S_D1, S_D2, S_RED, S_GCD, S_GW, S_QN, S_QD, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  q_item_t           it_r, it_nxt;
  logic [RNUM_W-1:0] x_r, x_nxt;
  logic [RDEN_W-1:0] y_r, y_nxt;
  logic [DIV_W-1:0]  ga_r, ga_nxt;
  logic [DIV_W-1:0]  gb_r, gb_nxt;
  logic              ov_r, ov_nxt;
  logic [RNUM_W-1:0] on_r, on_nxt;
  logic [RDEN_W-1:0] od_r, od_nxt;
  logic              os_r, os_nxt;
  logic [NUM_W-1:0]  ma, mb;
  logic [2*NUM_W-1:0] prod;

  assign prod = ma * mb;

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    ga_nxt    = ga_r;
    gb_nxt    = gb_r;
    on_nxt    = on_r;
    od_nxt    = od_r;
    os_nxt    = os_r;
    ov_nxt    = (ov_r && out_stall);
    ma        = '0;
    mb        = '0;
    pop       = 1'b0;
    div_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop    = 1'b1;
          it_nxt = head_item;
          x_nxt  = RNUM_W'(head_item.an);
          y_nxt  = RDEN_W'(head_item.ad);
          unique case (head_item.cls)
            CL_PASS:   state_nxt = S_DONE;
            CL_ADDEQ: begin
              x_nxt     = RNUM_W'(head_item.an) + RNUM_W'(head_item.bn);
              state_nxt = S_DONE;
            end
            CL_ADD: begin
              // larger denominator over smaller one
              div_req.start = 1'b1;
              div_req.dvd   = head_item.b_gt_a ? DIV_W'(head_item.bd) : DIV_W'(head_item.ad);
              div_req.dvs   = head_item.b_gt_a ? DIV_W'(head_item.ad) : DIV_W'(head_item.bd);
              state_nxt     = S_ADIV;
            end
            CL_MUL:    state_nxt = S_M1;
            CL_DIVIDE: state_nxt = S_D1;
            CL_SIMP:   state_nxt = S_RED;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ADIV: begin
        if (div_rsp.done) state_nxt = (div_rsp.rem == '0) ? S_ASC : S_X1;
      end
      S_ASC: begin
        ma        = it_r.b_gt_a ? it_r.an : it_r.bn;
        mb        = NUM_W'(div_rsp.quo[DEN_W-1:0]);
        x_nxt     = RNUM_W'(prod);
        y_nxt     = it_r.b_gt_a ? RDEN_W'(it_r.bd) : RDEN_W'(it_r.ad);
        state_nxt = S_ASC2;
      end
      S_ASC2: begin
        x_nxt     = x_r + (it_r.b_gt_a ? RNUM_W'(it_r.bn) : RNUM_W'(it_r.an));
        state_nxt = S_DONE;
      end
      S_X1: begin
        ma        = it_r.an;
        mb        = NUM_W'(it_r.bd);
        x_nxt     = RNUM_W'(prod);
        state_nxt = S_X2;
      end
      S_X2: begin
        ma        = it_r.bn;
        mb        = NUM_W'(it_r.ad);
        y_nxt     = prod[RDEN_W-1:0];
        state_nxt = S_X3;
      end
      S_X3: begin
        x_nxt     = x_r + RNUM_W'(y_r);
        ma        = NUM_W'(it_r.ad);
        mb        = NUM_W'(it_r.bd);
        y_nxt     = prod[RDEN_W-1:0];
        state_nxt = S_DONE;
      end
      S_M1: begin
        ma        = it_r.an;
        mb        = it_r.bn;
        x_nxt     = RNUM_W'(prod);
        state_nxt = S_M2;
      end
      S_M2: begin
        ma        = NUM_W'(it_r.ad);
        mb        = NUM_W'(it_r.bd);
        y_nxt     = prod[RDEN_W-1:0];
        state_nxt = S_DONE;
      end
      S_D1: begin
        ma        = it_r.an;
        mb        = NUM_W'(it_r.bd);
        x_nxt     = RNUM_W'(prod);
        state_nxt = S_D2;
      end
      S_D2: begin
        ma        = NUM_W'(it_r.ad);
        mb        = it_r.bn;
        y_nxt     = prod[RDEN_W-1:0];
        state_nxt = S_RED;
      end
      S_RED: begin
        if (x_r == '0 || y_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          ga_nxt    = x_r[DIV_W-1:0];
          gb_nxt    = y_r;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        div_req.start = 1'b1;
        if (ga_r == '0) begin
          // gcd found in gb, divide the numerator first
          div_req.dvd = x_r[DIV_W-1:0];
          div_req.dvs = gb_r;
          state_nxt   = S_QN;
        end else begin
          div_req.dvd = gb_r;
          div_req.dvs = ga_r;
          state_nxt   = S_GW;
        end
      end
      S_GW: begin
        if (div_rsp.done) begin
          gb_nxt    = ga_r;
          ga_nxt    = div_rsp.rem;
          state_nxt = S_GCD;
        end
      end
      S_QN: begin
        if (div_rsp.done) begin
          x_nxt         = RNUM_W'(div_rsp.quo);
          div_req.start = 1'b1;
          div_req.dvd   = y_r;
          div_req.dvs   = gb_r;
          state_nxt     = S_QD;
        end
      end
      S_QD: begin
        if (div_rsp.done) begin
          y_nxt     = div_rsp.quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          on_nxt    = x_r;
          od_nxt    = y_r;
          os_nxt    = it_r.cls == CL_PASS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    it_r <= it_nxt;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    ga_r <= ga_nxt;
    gb_r <= gb_nxt;
    on_r <= on_nxt;
    od_r <= od_nxt;
    os_r <= os_nxt;
  end

  assign out_valid   = ov_r;
  assign out_res_num = on_r;
  assign out_res_den = od_r;
  assign out_skipped = os_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rfa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks on the fraction unit, bound to the top level.
// ----------------------------------------------------------------------------
module rfa_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [rfa_pkg::MODE_W-1:0] in_mode,
  input wire logic [rfa_pkg::NUM_W-1:0]  in_a_num,
  input wire logic [rfa_pkg::DEN_W-1:0]  in_a_den,
  input wire logic [rfa_pkg::NUM_W-1:0]  in_b_num,
  input wire logic [rfa_pkg::DEN_W-1:0]  in_b_den,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [rfa_pkg::RNUM_W-1:0] out_res_num,
  input wire logic [rfa_pkg::RDEN_W-1:0] out_res_den,
  input wire logic                       out_skipped
);
  import rfa_pkg::*;

  // a skipped result is operand A, so it fits the input widths
  a_skip_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skipped |->
      out_res_num[RNUM_W-1:NUM_W] == '0 && out_res_den[RDEN_W-1:DEN_W] == '0)
    else $error("skipped result wider than operand A");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res_num)
      && $stable(out_res_den) && $stable(out_skipped))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_a_num)
      && $stable(in_a_den) && $stable(in_b_num) && $stable(in_b_den))
    else $error("stalled input item changed");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_queue: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (.*);
`default_nettype wire
